@@ hw/rtl/dtic_pkg.sv @@
// dtic_pkg: types and constants for the decimal text to integer checker.
// Shared by dtic_step and decimal_text_to_int_checker; depends on nothing.

package dtic_pkg;

   // Parse phase codes
   localparam logic [1:0] PH_LEAD   = 2'd0;
   localparam logic [1:0] PH_SIGN   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_TRAIL  = 2'd3;

   // Magnitude limits, 33 bits wide
   localparam logic [32:0] POS_LIMIT = 33'd2147483647;
   localparam logic [32:0] NEG_LIMIT = 33'd2147483648;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] parsed_value;
      logic [7:0]         exit_code;
      logic               bad_number;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [31:0] magnitude;
      logic        negative;
      logic        error;
      logic        ended;
   } parse_state_type;

endpackage

@@ hw/rtl/dtic_step.sv @@
// dtic_step: next parse state and result for one text byte (combinational).
// Depends on dtic_pkg.

module dtic_step (
   input  dtic_pkg::parse_state_type cur_state,
   input  logic [7:0]                text_byte,
   output dtic_pkg::parse_state_type next_state,
   output dtic_pkg::rsp_word_type    result
);

   logic        is_space;
   logic        is_digit;
   logic [35:0] times_ten;
   logic [35:0] accum;
   logic [32:0] limit;
   logic        overflow;
   logic        final_error;
   logic [31:0] value;

   assign is_space = ((text_byte >= dtic_pkg::CH_TAB) && (text_byte <= dtic_pkg::CH_CR))
                     || (text_byte == dtic_pkg::CH_SPACE);
   assign is_digit = (text_byte >= dtic_pkg::CH_ZERO) && (text_byte <= dtic_pkg::CH_NINE);

   // magnitude * 10 as (m << 3) + (m << 1), plus the digit
   assign times_ten = {1'b0, cur_state.magnitude, 3'b000}
                    + {3'b000, cur_state.magnitude, 1'b0};
   assign accum     = times_ten + {32'd0, text_byte[3:0]};
   assign limit     = cur_state.negative ? dtic_pkg::NEG_LIMIT : dtic_pkg::POS_LIMIT;
   assign overflow  = accum > {3'b000, limit};

   always_comb begin
      next_state = cur_state;
      if (!cur_state.ended && !cur_state.error) begin
         if (text_byte == dtic_pkg::CH_NUL) begin
            next_state.ended = 1'b1;
            if (cur_state.phase == dtic_pkg::PH_LEAD || cur_state.phase == dtic_pkg::PH_SIGN) begin
               next_state.error = 1'b1;
            end
         end else begin
            unique case (cur_state.phase)
               dtic_pkg::PH_LEAD: begin
                  if (is_space) begin
                     next_state.phase = dtic_pkg::PH_LEAD;
                  end else if (text_byte == dtic_pkg::CH_PLUS
                               || text_byte == dtic_pkg::CH_MINUS) begin
                     next_state.negative = (text_byte == dtic_pkg::CH_MINUS);
                     next_state.phase    = dtic_pkg::PH_SIGN;
                  end else if (is_digit) begin
                     next_state.phase = dtic_pkg::PH_DIGITS;
                     if (overflow) next_state.error = 1'b1;
                     else          next_state.magnitude = accum[31:0];
                  end else begin
                     next_state.error = 1'b1;
                  end
               end
               dtic_pkg::PH_SIGN, dtic_pkg::PH_DIGITS: begin
                  if (is_digit) begin
                     next_state.phase = dtic_pkg::PH_DIGITS;
                     if (overflow) next_state.error = 1'b1;
                     else          next_state.magnitude = accum[31:0];
                  end else if (is_space && cur_state.phase == dtic_pkg::PH_DIGITS) begin
                     next_state.phase = dtic_pkg::PH_TRAIL;
                  end else begin
                     next_state.error = 1'b1;
                  end
               end
               dtic_pkg::PH_TRAIL: begin
                  if (!is_space) next_state.error = 1'b1;
               end
               default: next_state.error = 1'b1;
            endcase
         end
      end
   end

   // Result as seen at the end of the string
   assign final_error = next_state.error
                        || (!next_state.ended && (next_state.phase == dtic_pkg::PH_LEAD
                                                  || next_state.phase == dtic_pkg::PH_SIGN));
   assign value = final_error        ? 32'd0 :
                  next_state.negative ? (32'd0 - next_state.magnitude) :
                                        next_state.magnitude;

   assign result.parsed_value = value;
   assign result.exit_code    = value[7:0];
   assign result.bad_number   = final_error;

endmodule

@@ hw/rtl/decimal_text_to_int_checker.sv @@
// decimal_text_to_int_checker: strict signed decimal parser, one byte per word.
// The word marked last is taken into the input register, then its result is registered
// in the result register. Depends on dtic_pkg, dtic_step.
// Throughput: one input word per cycle unless a last word waits on a stalled, full
// result register; a single parse step lies between input and state / result registers.
// Reset (sync, active high) empties both registers, parser back to leading whitespace.

module decimal_text_to_int_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dtic_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dtic_pkg::rsp_word_type rsp_word
);

   // Input register
   logic                      in_valid_ff, in_valid_in;
   dtic_pkg::req_word_type    in_word_ff;
   // Parse state carried between words of one string
   dtic_pkg::parse_state_type state_ff, state_in;
   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   dtic_pkg::rsp_word_type    rsp_word_ff;

   dtic_pkg::parse_state_type step_state;
   dtic_pkg::rsp_word_type    step_result;
   dtic_pkg::parse_state_type idle_state;

   logic advance;   // word in the input register is consumed this cycle
   logic load;      // new word taken from the input channel

   dtic_step u_step (
      .cur_state  (state_ff),
      .text_byte  (in_word_ff.text_byte),
      .next_state (step_state),
      .result     (step_result)
   );

   assign idle_state = '{phase: dtic_pkg::PH_LEAD, magnitude: 32'd0,
                         negative: 1'b0, error: 1'b0, ended: 1'b0};

   // Only a last word needs room in the result register; others pass freely.
   assign advance   = in_valid_ff && (!in_word_ff.last_byte || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   assign in_valid_in  = load || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && in_word_ff.last_byte) || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = in_word_ff.last_byte ? idle_state : step_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= idle_state;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         in_word_ff <= req_word;
      end
      if (advance && in_word_ff.last_byte) begin
         rsp_word_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks

   // The input side only stalls while a word waits in the input register.
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall raised with empty input register");

   // An error result carries a zero value.
   a_error_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.bad_number) |-> (rsp_word.parsed_value == 32'sd0))
      else $error("bad_number set with nonzero parsed_value");

   // Accumulated magnitude never passes the limit for its sign.
   a_magnitude_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, state_ff.magnitude} <= (state_ff.negative ? dtic_pkg::NEG_LIMIT
                                                       : dtic_pkg::POS_LIMIT)))
      else $error("magnitude beyond limit");

   // After a last word is consumed the parser is back in its start state.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && in_word_ff.last_byte) |=>
         (state_ff.phase == dtic_pkg::PH_LEAD && !state_ff.error && !state_ff.ended
          && state_ff.magnitude == 32'd0))
      else $error("parser not restarted after last word");

endmodule
